@@ design/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// shared types, widths and codes for the point in convex polygon block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pip_pkg;

    // table and coordinate geometry
    localparam int MAX_VERTICES  = 64;
    localparam int COORD_BITS    = 16;
    localparam int ADDR_BITS     = $clog2(MAX_VERTICES);
    localparam int CNT_BITS      = $clog2(MAX_VERTICES + 1);
    localparam int ENTRY_BITS    = 2 * COORD_BITS;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS     = 2 * DIFF_BITS;

    // fixed field widths
    localparam int INDEX_BITS    = 6;
    localparam int VCOUNT_BITS   = 7;
    localparam int MIN_VERTICES  = 3;

    // configuration port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = VCOUNT_BITS'(MIN_VERTICES);

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CODE_INSIDE    = 2'd0,
        CODE_BOUNDARY  = 2'd1,
        CODE_COLLINEAR = 2'd2,
        CODE_OUTSIDE   = 2'd3
    } t_code;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic                 start;
        logic                 wr_en;
        logic                 rd_en;
        logic                 close;
        logic [ADDR_BITS-1:0] addr;
        logic                 out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic found;
        logic out_free;
    } t_dp_stat;

    // vertex count limited to the legal range
    function automatic logic [CNT_BITS-1:0] clamp_count(input logic [VCOUNT_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w < 32'(MIN_VERTICES)) begin
            return CNT_BITS'(MIN_VERTICES);
        end else if (w > 32'(MAX_VERTICES)) begin
            return CNT_BITS'(MAX_VERTICES);
        end
        return CNT_BITS'(w);
    endfunction

endpackage

@@ design/pip_if.sv @@
// ----------------------------------------------------------------------------
// pip channel interfaces
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pip_req_if import pip_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [INDEX_BITS-1:0]         vertex_index;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;

    modport source (output valid, req_type, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, req_type, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_rsp_if import pip_pkg::*;;
    logic       valid;
    logic       ready;
    logic [1:0] position_code;

    modport source (output valid, position_code, input ready);
    modport sink   (input valid, position_code, output ready);
endinterface

@@ design/point_in_convex_polygon.sv @@
// ----------------------------------------------------------------------------
// point_in_convex_polygon
// path: a query walks the table through the read, product and decision stages
//   into the result register; a collinear edge ends the walk early
// throughput: one edge per cycle through the table read port and product stage;
//   a vertex load every cycle while idle, and no new request while a query walks
// reset: synchronous active low; vertex count returns to 3, table is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_convex_polygon import pip_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    pip_req_if.sink                  i_req,
    pip_rsp_if.source                o_rsp,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    // vertex count register, written on the apb access phase
    logic [VCOUNT_BITS-1:0] r_vertex_count;
    logic                   reg_hit;

    // command and status between the sequencer and the datapath
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // register index sits above the byte offset
    assign reg_hit = (paddr[CFG_ADDR_BITS-1:2] == REG_VERTEX_COUNT);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_vertex_count <= pwdata[VCOUNT_BITS-1:0];
        end
    end

    // read back the register, zero elsewhere
    assign prdata = reg_hit ? CFG_DATA_BITS'(r_vertex_count) : '0;

    // sequencer: takes requests only when idle, walks the vertices and closing edge
    pip_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req.valid),
        .i_req_type     (i_req.req_type),
        .o_req_ready    (i_req.ready),
        .i_vertex_count (r_vertex_count),
        .i_stat         (stat),
        .o_cmd          (cmd)
    );

    // datapath: table memory, three-stage edge pipeline, result register
    pip_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_vertex_index (i_req.vertex_index),
        .i_coord_x      (i_req.coord_x),
        .i_coord_y      (i_req.coord_y),
        .o_rsp          (o_rsp)
    );

endmodule

@@ design/pip_ctrl.sv @@
// ----------------------------------------------------------------------------
// pip_ctrl
// request sequencer: takes requests, walks the vertex table, hands off results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_ctrl import pip_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_type,
    output logic                   o_req_ready,
    input  logic [VCOUNT_BITS-1:0] i_vertex_count,
    input  t_dp_stat               i_stat,
    output t_dp_cmd                o_cmd
);

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [CNT_BITS-1:0] r_n, n_n;
    logic                take_query;

    assign take_query = (r_state == ST_IDLE) && i_req_valid && (i_req_type == REQ_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_n     <= CNT_BITS'(MIN_VERTICES);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        unique case (r_state)
            ST_IDLE: begin
                if (take_query) begin
                    n_state = ST_ISSUE;
                    n_cnt   = '0;
                    n_n     = clamp_count(i_vertex_count);
                end
            end
            ST_ISSUE: begin
                n_cnt = r_cnt + CNT_BITS'(1);
                if (i_stat.found) begin
                    n_state = ST_DONE;
                end else if (r_cnt == r_n) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_stat.found) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready    = 1'b0;
        o_cmd          = '0;
        o_cmd.addr     = r_cnt[ADDR_BITS-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.start  = take_query;
                o_cmd.wr_en  = i_req_valid && (i_req_type == REQ_LOAD);
            end
            ST_ISSUE: begin
                o_cmd.rd_en  = !i_stat.found && (r_cnt < r_n);
                o_cmd.close  = !i_stat.found && (r_cnt == r_n);
            end
            ST_WAIT: begin
                o_cmd.rd_en  = 1'b0;
            end
            ST_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: o_req_ready = 1'b0;
        endcase
    end

endmodule

@@ design/pip_dp.sv @@
// ----------------------------------------------------------------------------
// pip_dp
// vertex table, edge pipeline (read, products, sign compare) and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_dp import pip_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_stat                     o_stat,
    input  logic [INDEX_BITS-1:0]        i_vertex_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    pip_rsp_if.source                    o_rsp
);

    logic [ENTRY_BITS-1:0] mem [MAX_VERTICES];

    // query point
    logic signed [COORD_BITS-1:0] r_px, r_py;

    // read stage
    logic [ENTRY_BITS-1:0] r_rd_data;
    logic                  r_rd_valid, r_rd_first, r_rd_close;

    // walk state
    logic [ENTRY_BITS-1:0] r_v0, r_prev;

    // product stage
    logic signed [PROD_BITS-1:0] r_p1, r_p2, r_d1, r_d2;
    logic                        r_e_valid, r_e_last;

    // decision stage
    logic  r_found, r_have_last, r_last_pos, r_changed;
    t_code r_code;

    // output register
    logic  r_out_valid;
    t_code r_out_code;

    logic [ENTRY_BITS-1:0]        end_v;
    logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
    logic signed [DIFF_BITS-1:0]  dxp, dyp, dxe, dye, dxpe, dype;
    logic signed [PROD_BITS:0]    dot;
    logic                         cross_zero, cross_pos, on_seg, flip, changed_nx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && (32'(i_vertex_index) < 32'(MAX_VERTICES))) begin
            mem[ADDR_BITS'(i_vertex_index)] <= {i_coord_x, i_coord_y};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
    end

    // stage one: edge from the previous vertex to the one read, or the closing edge
    assign end_v = r_rd_close ? r_v0 : r_rd_data;
    assign sx    = r_prev[ENTRY_BITS-1:COORD_BITS];
    assign sy    = r_prev[COORD_BITS-1:0];
    assign ex    = end_v[ENTRY_BITS-1:COORD_BITS];
    assign ey    = end_v[COORD_BITS-1:0];
    assign dxp   = DIFF_BITS'(r_px) - DIFF_BITS'(sx);
    assign dyp   = DIFF_BITS'(r_py) - DIFF_BITS'(sy);
    assign dxe   = DIFF_BITS'(ex) - DIFF_BITS'(sx);
    assign dye   = DIFF_BITS'(ey) - DIFF_BITS'(sy);
    assign dxpe  = DIFF_BITS'(r_px) - DIFF_BITS'(ex);
    assign dype  = DIFF_BITS'(r_py) - DIFF_BITS'(ey);

    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            if (r_rd_first) begin
                r_v0 <= end_v;
            end
            r_prev <= end_v;
        end
        r_p1 <= dxp * dye;
        r_p2 <= dyp * dxe;
        r_d1 <= dxp * dxpe;
        r_d2 <= dyp * dype;
    end

    // stage two: sign of the cross product and the dot test
    assign cross_zero = (r_p1 == r_p2);
    assign cross_pos  = (r_p1 > r_p2);
    assign dot        = (PROD_BITS+1)'(r_d1) + (PROD_BITS+1)'(r_d2);
    assign on_seg     = dot[PROD_BITS] || (dot == '0);
    assign flip       = r_have_last && (cross_pos != r_last_pos);
    assign changed_nx = r_changed || flip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start) begin
            r_rd_valid  <= 1'b0;
            r_rd_first  <= 1'b0;
            r_rd_close  <= 1'b0;
            r_e_valid   <= 1'b0;
            r_e_last    <= 1'b0;
            r_found     <= 1'b0;
            r_have_last <= 1'b0;
            r_last_pos  <= 1'b0;
            r_changed   <= 1'b0;
            r_code      <= CODE_INSIDE;
        end else begin
            r_rd_valid <= i_cmd.rd_en || i_cmd.close;
            r_rd_first <= i_cmd.rd_en && (i_cmd.addr == '0);
            r_rd_close <= i_cmd.close;
            r_e_valid  <= r_rd_valid && !r_rd_first;
            r_e_last   <= r_rd_close;
            if (r_e_valid && !r_found) begin
                if (cross_zero) begin
                    r_found <= 1'b1;
                    r_code  <= on_seg ? CODE_BOUNDARY : CODE_COLLINEAR;
                end else begin
                    r_have_last <= 1'b1;
                    r_last_pos  <= cross_pos;
                    r_changed   <= changed_nx;
                    if (r_e_last) begin
                        r_found <= 1'b1;
                        r_code  <= changed_nx ? CODE_OUTSIDE : CODE_INSIDE;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_code <= r_code;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.position_code = r_out_code;
    assign o_stat.found        = r_found;
    assign o_stat.out_free     = !r_out_valid || o_rsp.ready;

endmodule

@@ design/pip_checker.sv @@
// ----------------------------------------------------------------------------
// pip_checker
// port-level checks on the point in convex polygon block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_checker import pip_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_type,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_code
);

    // a waiting result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_code))
        else $error("result dropped or changed while stalled");

    // a query closes the request side while it is walked
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_type == REQ_QUERY) |=> !i_in_ready)
        else $error("request taken during a query");

    // a load never makes a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_type == REQ_LOAD) && !i_out_valid |=> !i_out_valid)
        else $error("result after a vertex load");

    // nothing comes out right after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind point_in_convex_polygon pip_checker u_pip_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_type   (i_req.req_type),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_code  (o_rsp.position_code)
);
